/* rtl/ptwa_pkg.sv */
// Package for the page translation block with frame aging.
// Holds command codes, stream field layout and entry bit positions.
// No dependencies.
`default_nettype none

package ptwa_pkg;

	// command codes carried in the low bits of the input beat
	typedef enum logic [2:0] {
		CMD_TRANSLATE = 3'd0,
		CMD_MAP       = 3'd1,
		CMD_UNMAP     = 3'd2,
		CMD_TICK      = 3'd3,
		CMD_VICTIM    = 3'd4
	} cmd_t;

	// address split
	localparam int OFFSET_BITS = 12;

	// input field widths and positions in s_axis_tdata
	localparam int CMD_BITS       = 3;
	localparam int VA_BITS        = 24;
	localparam int MAP_FRAME_BITS = 10;
	localparam int IN_TDATA_BITS  = 40;
	localparam int VA_LSB         = CMD_BITS;
	localparam int WR_LSB         = VA_LSB + VA_BITS;
	localparam int MF_LSB         = WR_LSB + 1;

	// output field widths and positions in m_axis_tdata
	localparam int PHYS_BITS      = 22;
	localparam int VICT_BITS      = 10;
	localparam int OUT_TDATA_BITS = 40;
	localparam int OUT_USED_BITS  = PHYS_BITS + 1 + VICT_BITS + 1;

	// page entry layout: present, referenced, modified, then frame
	localparam int PE_PRESENT     = 0;
	localparam int PE_REF         = 1;
	localparam int PE_MOD         = 2;
	localparam int PE_FRAME_LSB   = 3;

	// age word layout: 8-bit age, allocated flag on top
	localparam int AGE_BITS       = 8;
	localparam int AGE_WORD_BITS  = AGE_BITS + 1;
	localparam int AGE_ALLOC      = AGE_BITS;

endpackage

`default_nettype wire

/* rtl/ptwa_ram.sv */
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Read data appears in the cycle after the read enable. No package dependency.
`default_nettype none

module ptwa_ram #(
	parameter int ADDR_BITS = 12,
	parameter int DATA_BITS = 13
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [ADDR_BITS-1:0] wr_addr,
	input  wire logic [DATA_BITS-1:0] wr_data,
	input  wire logic                 rd_en,
	input  wire logic [ADDR_BITS-1:0] rd_addr,
	output logic      [DATA_BITS-1:0] rd_data
);

	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/page_translation_with_aging_core.sv */
// Top level of the two-level page table with per-frame aging.
// Depends on ptwa_pkg and ptwa_ram (page table and age table memories).
//
// Usage:
//  One command beat in on s_axis, exactly one result beat out on m_axis.
//  Commands: translate, map, unmap, age tick, select victim.
//  After reset the block runs a clearing pass over both tables with
//  s_axis_tready low; then it takes commands one at a time.
//  Steps per command, accept to result in the output register: map
//  writes the entry at accept; translate and unmap read the page table,
//  then write the entry if present; age tick reads every page entry,
//  clearing the referenced bit and updating the age word of each present
//  one; select victim scans the age words, stopping early on a free frame.
//  The walks are bound by the single read port of each table memory.
//  The result sits in an output register; while m_axis stalls the block
//  finishes the next command and holds it until the output register frees.
//  Reset drops m_axis_tvalid and restarts the clearing pass.
`default_nettype none

module page_translation_with_aging_core #(
	parameter int LEVEL_BITS = 6,
	parameter int FRAME_BITS = 10
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// tdata: command[2:0], virtual_addr[26:3], is_write[27], map_frame[37:28]
	input  wire logic [ptwa_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// tdata: phys_addr[21:0], page_fault[22], victim_frame[32:23],
	//        victim_was_free[33]
	output logic      [ptwa_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready
);

	import ptwa_pkg::*;

	localparam int ENTRY_BITS = 2 * LEVEL_BITS;
	localparam int PE_BITS    = FRAME_BITS + PE_FRAME_LSB;
	localparam int CLR_BITS   = (ENTRY_BITS > FRAME_BITS) ? ENTRY_BITS : FRAME_BITS;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_XLATE,
		S_UNMAP,
		S_TICK_P,
		S_TICK_A,
		S_VICTIM,
		S_EMIT
	} state_t;

	state_t state_q;

	// input field extraction
	cmd_t                      in_cmd;
	logic [VA_BITS-1:0]        in_va;
	logic                      in_wr;
	logic [MAP_FRAME_BITS-1:0] in_mf;
	logic                      in_acc;
	logic [ENTRY_BITS+VA_BITS-1:0]        va_ext;
	logic [FRAME_BITS+MAP_FRAME_BITS-1:0] mf_ext;
	logic [ENTRY_BITS-1:0]     in_idx;
	logic [FRAME_BITS-1:0]     in_frame;

	assign in_cmd   = cmd_t'(s_axis_tdata[CMD_BITS-1:0]);
	assign in_va    = s_axis_tdata[VA_LSB +: VA_BITS];
	assign in_wr    = s_axis_tdata[WR_LSB];
	assign in_mf    = s_axis_tdata[MF_LSB +: MAP_FRAME_BITS];
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign va_ext   = {{ENTRY_BITS{1'b0}}, in_va};
	assign in_idx   = va_ext[OFFSET_BITS +: ENTRY_BITS];
	assign mf_ext   = {{FRAME_BITS{1'b0}}, in_mf};
	assign in_frame = mf_ext[FRAME_BITS-1:0];

	// working registers
	logic [CLR_BITS-1:0]      clr_q;
	logic [ENTRY_BITS-1:0]    idx_q;
	logic [OFFSET_BITS-1:0]   off_q;
	logic                     wr_q;
	logic [ENTRY_BITS-1:0]    tick_q;
	logic [PE_BITS-1:0]       pe_q;
	logic [FRAME_BITS-1:0]    vic_q;
	logic [FRAME_BITS-1:0]    best_q;
	logic [AGE_WORD_BITS-1:0] best_age_q;

	// pending result
	logic [PHYS_BITS-1:0]     res_pa_q;
	logic                     res_fault_q;
	logic [VICT_BITS-1:0]     res_vf_q;
	logic                     res_free_q;

	// memory ports
	logic                     pt_wr_en, pt_rd_en;
	logic [ENTRY_BITS-1:0]    pt_wr_addr, pt_rd_addr;
	logic [PE_BITS-1:0]       pt_wr_data, pt_rd_data;
	logic                     ag_wr_en, ag_rd_en;
	logic [FRAME_BITS-1:0]    ag_wr_addr, ag_rd_addr;
	logic [AGE_WORD_BITS-1:0] ag_wr_data, ag_rd_data;

	ptwa_ram #(
		.ADDR_BITS (ENTRY_BITS),
		.DATA_BITS (PE_BITS)
	) u_page_ram (
		.clk     (clk),
		.wr_en   (pt_wr_en),
		.wr_addr (pt_wr_addr),
		.wr_data (pt_wr_data),
		.rd_en   (pt_rd_en),
		.rd_addr (pt_rd_addr),
		.rd_data (pt_rd_data)
	);

	ptwa_ram #(
		.ADDR_BITS (FRAME_BITS),
		.DATA_BITS (AGE_WORD_BITS)
	) u_age_ram (
		.clk     (clk),
		.wr_en   (ag_wr_en),
		.wr_addr (ag_wr_addr),
		.wr_data (ag_wr_data),
		.rd_en   (ag_rd_en),
		.rd_addr (ag_rd_addr),
		.rd_data (ag_rd_data)
	);

	// decoded read data
	logic                  rd_present;
	logic [FRAME_BITS-1:0] rd_frame;
	logic [FRAME_BITS-1:0] pe_q_frame;
	logic                  tick_last, vic_last;

	assign rd_present = pt_rd_data[PE_PRESENT];
	assign rd_frame   = pt_rd_data[PE_FRAME_LSB +: FRAME_BITS];
	assign pe_q_frame = pe_q[PE_FRAME_LSB +: FRAME_BITS];
	assign tick_last  = &tick_q;
	assign vic_last   = &vic_q;

	// translated address, truncated to the output field
	logic [PHYS_BITS+FRAME_BITS+OFFSET_BITS-1:0] pa_ext;
	assign pa_ext = {{PHYS_BITS{1'b0}}, rd_frame, off_q};

	// victim scan: candidate pick and its truncation to the output field
	logic                          vic_free, vic_better;
	logic [FRAME_BITS-1:0]         vic_pick;
	logic [VICT_BITS+FRAME_BITS-1:0] vic_ext;

	assign vic_free   = !ag_rd_data[AGE_ALLOC];
	assign vic_better = {1'b0, ag_rd_data[AGE_BITS-1:0]} < best_age_q;
	assign vic_pick   = (vic_free || vic_better) ? vic_q : best_q;
	assign vic_ext    = {{VICT_BITS{1'b0}}, vic_pick};

	assign s_axis_tready = (state_q == S_IDLE);

	// memory port control
	always_comb begin
		pt_wr_en   = 1'b0;
		pt_wr_addr = idx_q;
		pt_wr_data = '0;
		pt_rd_en   = 1'b0;
		pt_rd_addr = in_idx;
		ag_wr_en   = 1'b0;
		ag_wr_addr = rd_frame;
		ag_wr_data = '0;
		ag_rd_en   = 1'b0;
		ag_rd_addr = '0;
		unique case (state_q)
			S_CLEAR: begin
				pt_wr_en   = 1'b1;
				pt_wr_addr = clr_q[ENTRY_BITS-1:0];
				ag_wr_en   = 1'b1;
				ag_wr_addr = clr_q[FRAME_BITS-1:0];
			end
			S_IDLE: begin
				if (in_acc) begin
					case (in_cmd)
						CMD_TRANSLATE, CMD_UNMAP: begin
							pt_rd_en = 1'b1;
						end
						CMD_MAP: begin
							pt_wr_en   = 1'b1;
							pt_wr_addr = in_idx;
							pt_wr_data = '0;
							pt_wr_data[PE_FRAME_LSB +: FRAME_BITS] = in_frame;
							pt_wr_data[PE_PRESENT] = 1'b1;
						end
						CMD_TICK: begin
							pt_rd_en   = 1'b1;
							pt_rd_addr = '0;
						end
						CMD_VICTIM: begin
							ag_rd_en = 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_XLATE: begin
				if (rd_present) begin
					pt_wr_en   = 1'b1;
					pt_wr_data = pt_rd_data;
					pt_wr_data[PE_REF] = 1'b1;
					pt_wr_data[PE_MOD] = pt_rd_data[PE_MOD] | wr_q;
				end
			end
			S_UNMAP: begin
				if (rd_present) begin
					pt_wr_en = 1'b1;
					ag_wr_en = 1'b1;
				end
			end
			S_TICK_P: begin
				if (rd_present) begin
					ag_rd_en   = 1'b1;
					ag_rd_addr = rd_frame;
				end else if (!tick_last) begin
					pt_rd_en   = 1'b1;
					pt_rd_addr = tick_q + 1'b1;
				end
			end
			S_TICK_A: begin
				// shift referenced bit into the age, mark frame allocated
				pt_wr_en   = 1'b1;
				pt_wr_addr = tick_q;
				pt_wr_data = pe_q;
				pt_wr_data[PE_REF] = 1'b0;
				ag_wr_en   = 1'b1;
				ag_wr_addr = pe_q_frame;
				ag_wr_data = {1'b1, pe_q[PE_REF], ag_rd_data[AGE_BITS-1:1]};
				if (!tick_last) begin
					pt_rd_en   = 1'b1;
					pt_rd_addr = tick_q + 1'b1;
				end
			end
			S_VICTIM: begin
				ag_rd_en   = 1'b1;
				ag_rd_addr = vic_q + 1'b1;
			end
			S_EMIT: ;
			default: ;
		endcase
	end

	// sequencer, working registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			tick_q        <= '0;
			vic_q         <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			// beat taken; a new one loaded in S_EMIT keeps valid high
			if (m_axis_tvalid && m_axis_tready && state_q != S_EMIT) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						idx_q       <= in_idx;
						off_q       <= in_va[OFFSET_BITS-1:0];
						wr_q        <= in_wr;
						tick_q      <= '0;
						vic_q       <= '0;
						best_q      <= '0;
						best_age_q  <= AGE_WORD_BITS'(1 << AGE_BITS);
						res_pa_q    <= '0;
						res_fault_q <= 1'b0;
						res_vf_q    <= '0;
						res_free_q  <= 1'b0;
						case (in_cmd)
							CMD_TRANSLATE: state_q <= S_XLATE;
							CMD_UNMAP:     state_q <= S_UNMAP;
							CMD_TICK:      state_q <= S_TICK_P;
							CMD_VICTIM:    state_q <= S_VICTIM;
							default:       state_q <= S_EMIT;
						endcase
					end
				end
				S_XLATE: begin
					if (rd_present) begin
						res_pa_q <= pa_ext[PHYS_BITS-1:0];
					end else begin
						res_fault_q <= 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_UNMAP: begin
					state_q <= S_EMIT;
				end
				S_TICK_P: begin
					pe_q <= pt_rd_data;
					if (rd_present) begin
						state_q <= S_TICK_A;
					end else if (tick_last) begin
						state_q <= S_EMIT;
					end else begin
						tick_q <= tick_q + 1'b1;
					end
				end
				S_TICK_A: begin
					if (tick_last) begin
						state_q <= S_EMIT;
					end else begin
						tick_q  <= tick_q + 1'b1;
						state_q <= S_TICK_P;
					end
				end
				S_VICTIM: begin
					if (vic_better) begin
						best_age_q <= {1'b0, ag_rd_data[AGE_BITS-1:0]};
						best_q     <= vic_q;
					end
					vic_q <= vic_q + 1'b1;
					if (vic_free || vic_last) begin
						res_vf_q   <= vic_ext[VICT_BITS-1:0];
						res_free_q <= vic_free;
						state_q    <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tdata  <= {{(OUT_TDATA_BITS-OUT_USED_BITS){1'b0}},
							res_free_q, res_vf_q, res_fault_q, res_pa_q};
						m_axis_tvalid <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* tb/tb_page_translation_with_aging_core.sv */
// Self-checking testbench for page_translation_with_aging_core: page table and age table shadow,
// directed corner cases, random command mix, frame aging and back-to-back streaming.
// Depends on ptwa_pkg and the core RTL; needs no files or arguments.
`default_nettype none

module tb_page_translation_with_aging_core;
	import ptwa_pkg::*;

	localparam int LVL_BITS = 6;
	localparam int FRM_BITS = 10;
	localparam int N_ENTRY  = 1 << (2 * LVL_BITS);
	localparam int N_FRAME  = 1 << FRM_BITS;
	localparam int HOT_N    = 16;
	localparam int AGED_N   = 256;

	// codes the block does not define
	localparam logic [2:0] CMD_RSVD_A = 3'd5;
	localparam logic [2:0] CMD_RSVD_B = 3'd6;
	localparam logic [2:0] CMD_RSVD_C = 3'd7;

	// result fields, last field in the low bits
	typedef struct packed {
		logic                 victim_was_free;
		logic [VICT_BITS-1:0] victim_frame;
		logic                 page_fault;
		logic [PHYS_BITS-1:0] phys_addr;
	} xlat_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
	logic                      s_axis_tvalid;
	wire logic                 s_axis_tready;
	wire logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
	wire logic                 m_axis_tvalid;
	logic                      m_axis_tready;

	// shadow of the page table and the age table
	logic [12:0] pte_shadow [N_ENTRY];
	logic [8:0]  age_shadow [N_FRAME];

	xlat_result_t pending_results[$];
	logic [11:0]  hot_entry [HOT_N];
	bit           idle_on;
	int           fail_count = 0;

	page_translation_with_aging_core #(
		.LEVEL_BITS(LVL_BITS),
		.FRAME_BITS(FRM_BITS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run one command against the shadow tables, return its result beat
	function automatic xlat_result_t page_table_step(logic [2:0] cmd, logic [23:0] va,
			logic wr, logic [9:0] mf);
		xlat_result_t r;
		logic [11:0]  idx;
		logic [12:0]  e;
		logic [12:0]  pe;
		logic [9:0]   f;
		int           best;
		int           best_age;
		bit           found;
		r = '0;
		idx = va[23:12];
		e = pte_shadow[idx];
		case (cmd)
			CMD_TRANSLATE: begin
				if (!e[PE_PRESENT]) begin
					r.page_fault = 1'b1;
				end else begin
					r.phys_addr = {e[PE_FRAME_LSB +: FRM_BITS], va[11:0]};
					e[PE_REF] = 1'b1;
					if (wr) e[PE_MOD] = 1'b1;
					pte_shadow[idx] = e;
				end
			end
			CMD_MAP: pte_shadow[idx] = {mf, 3'b001};
			CMD_UNMAP: begin
				if (e[PE_PRESENT]) begin
					age_shadow[e[PE_FRAME_LSB +: FRM_BITS]] = '0;
					pte_shadow[idx] = '0;
				end
			end
			CMD_TICK: begin
				// walk in index order; shared frames age once per entry
				for (int i = 0; i < N_ENTRY; i++) begin
					pe = pte_shadow[i];
					if (pe[PE_PRESENT]) begin
						f = pe[PE_FRAME_LSB +: FRM_BITS];
						age_shadow[f] = {1'b1, pe[PE_REF], age_shadow[f][AGE_BITS-1:1]};
						pte_shadow[i][PE_REF] = 1'b0;
					end
				end
			end
			CMD_VICTIM: begin
				best = 0;
				best_age = 256;
				found = 1'b0;
				for (int i = 0; i < N_FRAME && !found; i++) begin
					if (!age_shadow[i][AGE_ALLOC]) begin
						best = i;
						found = 1'b1;
					end else if (int'(age_shadow[i][AGE_BITS-1:0]) < best_age) begin
						best_age = int'(age_shadow[i][AGE_BITS-1:0]);
						best = i;
					end
				end
				r.victim_frame = 10'(best);
				r.victim_was_free = found;
			end
			default: ;
		endcase
		return r;
	endfunction

	// drive one command beat, with an optional gap ahead of it
	task automatic send_cmd(input logic [2:0] cmd, input logic [23:0] va, input logic wr,
			input logic [9:0] mf);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_axis_tdata  <= {2'b00, mf, wr, va, cmd};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(page_table_step(cmd, va, wr, mf));
	endtask

	// one random command, mostly on a small set of hot pages
	task automatic send_mixed_item();
		int          pick;
		logic [11:0] idx;
		logic [9:0]  frame;
		logic [2:0]  cmd;
		pick = $urandom_range(0, 99);
		idx = ($urandom_range(0, 9) == 0) ? 12'($urandom) : hot_entry[$urandom_range(0, HOT_N-1)];
		frame = ($urandom_range(0, 1) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
		if (pick < 45)      cmd = CMD_TRANSLATE;
		else if (pick < 70) cmd = CMD_MAP;
		else if (pick < 82) cmd = CMD_UNMAP;
		else if (pick < 86) cmd = CMD_TICK;
		else if (pick < 96) cmd = CMD_VICTIM;
		else if (pick < 97) cmd = CMD_RSVD_A;
		else if (pick < 98) cmd = CMD_RSVD_B;
		else                cmd = CMD_RSVD_C;
		send_cmd(cmd, {idx, 12'($urandom)}, 1'($urandom), frame);
	endtask

	// corner cases: empty tables, field extremes, overwrite, sharing, reserved codes
	task automatic test_directed();
		send_cmd(CMD_VICTIM, 24'h000000, 1'b0, 10'd0);
		send_cmd(CMD_TRANSLATE, 24'h000000, 1'b0, 10'd0);
		send_cmd(CMD_TRANSLATE, 24'hFFFFFF, 1'b1, 10'h3FF);
		send_cmd(CMD_MAP, 24'h000000, 1'b0, 10'd0);
		send_cmd(CMD_MAP, 24'hFFFFFF, 1'b1, 10'h3FF);
		send_cmd(CMD_TRANSLATE, 24'h000FFF, 1'b0, 10'd0);
		send_cmd(CMD_TRANSLATE, 24'hFFFFFF, 1'b1, 10'd0);
		// remap a present page: fresh entry, ref and mod cleared
		send_cmd(CMD_MAP, 24'hFFF000, 1'b0, 10'd5);
		send_cmd(CMD_TRANSLATE, 24'hFFF123, 1'b0, 10'd0);
		// second page on frame 0
		send_cmd(CMD_MAP, 24'h001000, 1'b0, 10'd0);
		send_cmd(CMD_TRANSLATE, 24'h001ABC, 1'b1, 10'd0);
		send_cmd(CMD_TICK, 24'h000000, 1'b0, 10'd0);
		send_cmd(CMD_TRANSLATE, 24'h000800, 1'b0, 10'd0);
		send_cmd(CMD_TICK, 24'hFFFFFF, 1'b1, 10'h3FF);
		send_cmd(CMD_VICTIM, 24'hFFFFFF, 1'b1, 10'h3FF);
		// unmap of an absent page changes nothing
		send_cmd(CMD_UNMAP, 24'h555000, 1'b0, 10'd0);
		send_cmd(CMD_UNMAP, 24'h001000, 1'b0, 10'd0);
		send_cmd(CMD_VICTIM, 24'h000000, 1'b0, 10'd0);
		send_cmd(CMD_TRANSLATE, 24'h001000, 1'b0, 10'd0);
		send_cmd(CMD_RSVD_A, 24'($urandom), 1'b1, 10'($urandom));
		send_cmd(CMD_RSVD_B, 24'hFFFFFF, 1'b1, 10'h3FF);
		send_cmd(CMD_RSVD_C, 24'($urandom), 1'($urandom), 10'($urandom));
		send_cmd(CMD_TRANSLATE, 24'h000000, 1'b0, 10'd0);
	endtask

	// random mix over a pool of hot pages
	task automatic test_random_mix();
		hot_entry[0] = 12'h000;
		hot_entry[1] = 12'hFFF;
		for (int i = 2; i < HOT_N; i++) hot_entry[i] = 12'($urandom);
		for (int n = 0; n < 200; n++) send_mixed_item();
	endtask

	// map a block of frames, then age them with varied references
	task automatic test_frame_aging();
		int          perm [AGED_N];
		logic [11:0] mapped_idx [AGED_N];
		int          j;
		int          t;
		for (int i = 0; i < AGED_N; i++) perm[i] = i;
		for (int i = AGED_N - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		for (int i = 0; i < AGED_N; i++) begin
			mapped_idx[i] = {10'(i), 2'($urandom)};
			send_cmd(CMD_MAP, {mapped_idx[i], 12'($urandom)}, 1'($urandom), 10'(perm[i]));
			if (i % 8 == 7)
				send_cmd(CMD_TRANSLATE, {mapped_idx[$urandom_range(0, i)], 12'($urandom)},
					1'($urandom), 10'($urandom));
		end
		send_cmd(CMD_TICK, 24'($urandom), 1'b0, 10'($urandom));
		send_cmd(CMD_VICTIM, 24'($urandom), 1'b0, 10'($urandom));
		for (int round = 0; round < 3; round++) begin
			for (int k = 0; k < 20; k++)
				send_cmd(CMD_TRANSLATE, {mapped_idx[$urandom_range(0, AGED_N-1)], 12'($urandom)},
					1'($urandom), 10'($urandom));
			send_cmd(CMD_TICK, 24'($urandom), 1'($urandom), 10'($urandom));
			send_cmd(CMD_VICTIM, 24'($urandom), 1'($urandom), 10'($urandom));
		end
		// unmapping frees frames again
		for (int k = 0; k < 3; k++) begin
			send_cmd(CMD_UNMAP, {mapped_idx[$urandom_range(0, AGED_N-1)], 12'($urandom)},
				1'($urandom), 10'($urandom));
			send_cmd(CMD_VICTIM, 24'($urandom), 1'($urandom), 10'($urandom));
		end
	endtask

	// closing stretch: no gaps and no stalls
	task automatic test_streaming();
		idle_on = 1'b0;
		for (int n = 0; n < 40; n++) send_mixed_item();
	endtask

	// result sink with random stall bursts
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin : chk_result
		xlat_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat tdata=%h", m_axis_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[0 +: PHYS_BITS] !== want.phys_addr) begin
					$error("phys_addr expected %h actual %h", want.phys_addr,
						m_axis_tdata[0 +: PHYS_BITS]);
					fail_count++;
				end
				if (m_axis_tdata[PHYS_BITS] !== want.page_fault) begin
					$error("page_fault expected %b actual %b", want.page_fault,
						m_axis_tdata[PHYS_BITS]);
					fail_count++;
				end
				if (m_axis_tdata[PHYS_BITS+1 +: VICT_BITS] !== want.victim_frame) begin
					$error("victim_frame expected %0d actual %0d", want.victim_frame,
						m_axis_tdata[PHYS_BITS+1 +: VICT_BITS]);
					fail_count++;
				end
				if (m_axis_tdata[PHYS_BITS+1+VICT_BITS] !== want.victim_was_free) begin
					$error("victim_was_free expected %b actual %b", want.victim_was_free,
						m_axis_tdata[PHYS_BITS+1+VICT_BITS]);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("[page_translation_with_aging_core] ERROR");
		$finish;
	end

	initial begin
		for (int i = 0; i < N_ENTRY; i++) pte_shadow[i] = '0;
		for (int i = 0; i < N_FRAME; i++) age_shadow[i] = '0;
		idle_on = 1'b1;
		s_axis_tdata = '0;
		s_axis_tvalid = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_mix();
		test_frame_aging();
		test_streaming();

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("[page_translation_with_aging_core] OK");
		end else begin
			$display("[page_translation_with_aging_core] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
